// ===== sv/pcr_pkg.sv =====
package pcr_pkg;

  localparam int unsigned MaxDevices = 16;
  localparam int unsigned DevW       = 4;
  localparam int unsigned DevLimit   = (MaxDevices < (1 << DevW)) ? MaxDevices : (1 << DevW);
  localparam int unsigned CellsMax   = 12;
  localparam int unsigned GroupStride = 3;
  localparam logic [15:0] PecSeed    = 16'd16;
  localparam logic [15:0] PecPoly    = 16'h4599;

  localparam logic [2:0] LastDataPos = 3'd5;
  localparam logic [2:0] PecHighPos  = 3'd6;
  localparam logic [2:0] PecLowPos   = 3'd7;

  typedef enum logic {
    CfgDeviceCount    = 1'b0,
    CfgCellsPerDevice = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [1:0] register_group;
    logic       start_of_read;
  } in_t;

  typedef struct packed {
    logic [15:0] cell_a;
    logic [15:0] cell_b;
    logic [15:0] cell_c;
    logic [7:0]  first_cell_index;
    logic        pec_ok;
    logic        read_error;
    logic        last_device;
  } out_t;

  typedef struct packed {
    logic [5:0][7:0]  data;
    logic [DevW-1:0]  device;
    logic [1:0]       group;
    logic             ok;
    logic             err;
    logic             last;
  } rec_t;

  function automatic logic [15:0] pec_step(input logic [15:0] rem, input logic [7:0] b);
    logic [7:0]  a;
    logic [15:0] r;
    a = rem[14:7] ^ b;
    r = {1'b0, a, 7'b0};
    for (int k = 0; k < 8; k++) begin
      if (r[14]) begin
        r = {r[14:0], 1'b0} ^ PecPoly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return {rem[7:0], 8'b0} ^ r;
  endfunction

endpackage

// ===== sv/pcr_front.sv =====
module pcr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pcr_pkg::in_t  in_data_i,
  input  logic [4:0]    device_count_i,
  input  logic          full_i,
  output logic          push_o,
  output pcr_pkg::rec_t rec_o
);

  logic [2:0]                 pos_q, pos_d, pos;
  logic [pcr_pkg::DevW-1:0]   dev_q, dev_d, dev;
  logic [15:0]                rem_q, rem_d, rem;
  logic                       err_q, err_d, err;
  logic [6:0][7:0]            bytes_q;
  logic                       acc, ok, last;
  logic [4:0]                 ndev;
  logic [15:0]                rx_pec;

  assign in_stall_o = full_i;
  assign acc        = in_valid_i && !full_i;

  always_comb begin
    if (device_count_i == 5'd0) begin
      ndev = 5'd1;
    end else if (device_count_i > 5'(pcr_pkg::DevLimit)) begin
      ndev = 5'(pcr_pkg::DevLimit);
    end else begin
      ndev = device_count_i;
    end
  end

  always_comb begin
    pos = in_data_i.start_of_read ? 3'd0 : pos_q;
    dev = in_data_i.start_of_read ? '0 : dev_q;
    rem = in_data_i.start_of_read ? pcr_pkg::PecSeed : rem_q;
    err = in_data_i.start_of_read ? 1'b0 : err_q;

    rx_pec = {bytes_q[pcr_pkg::PecHighPos], in_data_i.rx_byte};
    ok     = (rx_pec == {rem[14:0], 1'b0});
    last   = ({1'b0, dev} + 5'd1) >= ndev;

    pos_d  = pos_q;
    dev_d  = dev_q;
    rem_d  = rem_q;
    err_d  = err_q;
    push_o = 1'b0;

    if (acc) begin
      dev_d = dev;
      err_d = err;
      if (pos != pcr_pkg::PecLowPos) begin
        pos_d = pos + 3'd1;
        rem_d = (pos <= pcr_pkg::LastDataPos) ? pcr_pkg::pec_step(rem, in_data_i.rx_byte) : rem;
      end else begin
        push_o = 1'b1;
        pos_d  = 3'd0;
        rem_d  = pcr_pkg::PecSeed;
        err_d  = err | ~ok;
        dev_d  = last ? '0 : dev + 1'b1;
      end
    end
  end

  always_comb begin
    rec_o.data   = bytes_q[5:0];
    rec_o.device = dev;
    rec_o.group  = in_data_i.register_group;
    rec_o.ok     = ok;
    rec_o.err    = err | ~ok;
    rec_o.last   = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      dev_q <= '0;
      rem_q <= pcr_pkg::PecSeed;
      err_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      dev_q <= dev_d;
      rem_q <= rem_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && pos != pcr_pkg::PecLowPos) begin
      bytes_q[pos] <= in_data_i.rx_byte;
    end
  end

endmodule

// ===== sv/pcr_queue.sv =====
module pcr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pcr_pkg::rec_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output pcr_pkg::rec_t pop_data_o
);

  pcr_pkg::rec_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign full_o     = cnt_q[1];
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/pcr_back.sv =====
module pcr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rec_valid_i,
  input  pcr_pkg::rec_t rec_i,
  output logic          pop_o,
  input  logic [3:0]    cells_per_device_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pcr_pkg::out_t out_data_o
);

  logic          valid_q;
  pcr_pkg::out_t data_q, data_d;
  logic [3:0]    cpd;

  assign pop_o       = rec_valid_i && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    if (cells_per_device_i == 4'd0) begin
      cpd = 4'd1;
    end else if (cells_per_device_i > 4'(pcr_pkg::CellsMax)) begin
      cpd = 4'(pcr_pkg::CellsMax);
    end else begin
      cpd = cells_per_device_i;
    end
  end

  always_comb begin
    data_d.cell_a = rec_i.ok ? {rec_i.data[1], rec_i.data[0]} : 16'd0;
    data_d.cell_b = rec_i.ok ? {rec_i.data[3], rec_i.data[2]} : 16'd0;
    data_d.cell_c = rec_i.ok ? {rec_i.data[5], rec_i.data[4]} : 16'd0;
    data_d.first_cell_index = 8'({4'd0, rec_i.device} * {4'd0, cpd})
                            + 8'({6'd0, rec_i.group} * 8'(pcr_pkg::GroupStride));
    data_d.pec_ok      = rec_i.ok;
    data_d.read_error  = rec_i.err;
    data_d.last_device = rec_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== sv/pec15_checked_cell_register_reader.sv =====
// PEC-checked cell register readback.
// Input channel (in_valid_i / in_stall_o / in_data_i): one byte of the chain per beat,
// with the register group and a start-of-read flag that restarts the byte and device
// counters and clears the sticky error. Each device frame is 8 beats: six data bytes,
// then the PEC high and low bytes.
// Output channel (out_valid_o / out_stall_i / out_data_o): one beat per frame with the
// three cell words (zeroed on a PEC mismatch), first cell index, pec_ok, sticky
// read_error and last_device.
// Config port: cfg_we_i writes device_count (index 0) or cells_per_device (index 1);
// write only while idle.
// Throughput: one byte per cycle while in_stall_o is low. The front CRC/frame stage
// feeds a 2-entry frame queue; the back stage registers the result. A finished frame
// is written into the queue, then popped into the output register behind out_data_o.
// When the receiver stalls, the result holds in the output register and frames fill the
// queue; in_stall_o rises only when the queue is full.
// Reset: counters cleared, PEC seed loaded, device_count = 1, cells_per_device = 12,
// no result pending.
module pec15_checked_cell_register_reader (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pcr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pcr_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [4:0]    cfg_data_i
);

  logic [4:0]    device_count_q;
  logic [3:0]    cells_q;
  logic          push, full, pop, rec_valid;
  pcr_pkg::rec_t rec_in, rec_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_count_q <= 5'd1;
      cells_q        <= 4'(pcr_pkg::CellsMax);
    end else if (cfg_we_i) begin
      case (pcr_pkg::cfg_reg_e'(cfg_index_i))
        pcr_pkg::CfgDeviceCount:    device_count_q <= cfg_data_i;
        pcr_pkg::CfgCellsPerDevice: cells_q        <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  pcr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .device_count_i (device_count_q),
    .full_i         (full),
    .push_o         (push),
    .rec_o          (rec_in)
  );

  pcr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (rec_in),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (rec_valid),
    .pop_data_o  (rec_out)
  );

  pcr_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .rec_valid_i        (rec_valid),
    .rec_i              (rec_out),
    .pop_o              (pop),
    .cells_per_device_i (cells_q),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_data_o         (out_data_o)
  );

endmodule
